>>> design/x2u_pkg.sv
// ----------------------------------------------------------------------------
// x2u_pkg: shared definitions for the xml entity to utf-8 decoder
// Constants, character codes, entity table, state and result types, and the
// utf-8 encoder used by the decode logic.
// ----------------------------------------------------------------------------
package x2u_pkg;

	// name length bound and derived widths
	localparam int MAX_NAME_CHARS = 8;
	localparam int HASH_W         = 2 + 5 * MAX_NAME_CHARS;
	localparam int LEN_W          = $clog2(MAX_NAME_CHARS + 1);
	localparam int ACC_W          = 21;
	localparam int SUM_W          = ACC_W + 4;
	localparam int MAX_RES        = 4;
	localparam int CNT_W          = $clog2(MAX_RES + 1);
	localparam int N_ENT          = 5;

	localparam logic [SUM_W-1:0] CP_LIMIT = SUM_W'(24'h10FFFF);

	// character codes
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// hash offset of digits inside a name
	localparam logic [5:0] NAME_DIGIT_BASE = 6'd26;

	// known entities: euro, amp, lt, gt, quot
	localparam logic [HASH_W-1:0] ENT_HASH [N_ENT] = '{
		HASH_W'(64'd2249262), HASH_W'(64'd65935), HASH_W'(64'd2419),
		HASH_W'(64'd2259), HASH_W'(64'd2642387)
	};
	localparam logic [ACC_W-1:0] ENT_CP [N_ENT] = '{
		ACC_W'(8364), ACC_W'(38), ACC_W'(60), ACC_W'(62), ACC_W'(34)
	};

	// decode mode
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NAME,
		MODE_HASH,
		MODE_DIGITS
	} mode_t;

	// decoder state between characters
	typedef struct packed {
		mode_t             mode;
		logic              hex;
		logic [ACC_W-1:0]  acc;
		logic [HASH_W-1:0] hash;
		logic [LEN_W-1:0]  len;
	} dec_state_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_last;
		logic       is_error;
	} res_t;

	// all results of one character
	typedef struct packed {
		logic [CNT_W-1:0]        count;
		res_t [MAX_RES-1:0]      item;
	} burst_t;

	function automatic res_t mk_res(input logic [7:0] b, input logic last, input logic err);
		res_t r;
		r.out_byte = b;
		r.is_last  = last;
		r.is_error = err;
		return r;
	endfunction

	// code point to 1..4 utf-8 bytes
	function automatic burst_t utf8_encode(input logic [ACC_W-1:0] cp);
		burst_t b;
		b = '0;
		if (cp <= ACC_W'(12'h7F)) begin
			b.count   = CNT_W'(1);
			b.item[0] = mk_res({1'b0, cp[6:0]}, 1'b1, 1'b0);
		end else if (cp <= ACC_W'(12'h7FF)) begin
			b.count   = CNT_W'(2);
			b.item[0] = mk_res({3'b110, cp[10:6]}, 1'b0, 1'b0);
			b.item[1] = mk_res({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end else if (cp <= ACC_W'(16'hFFFF)) begin
			b.count   = CNT_W'(3);
			b.item[0] = mk_res({4'b1110, cp[15:12]}, 1'b0, 1'b0);
			b.item[1] = mk_res({2'b10, cp[11:6]}, 1'b0, 1'b0);
			b.item[2] = mk_res({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end else begin
			b.count   = CNT_W'(4);
			b.item[0] = mk_res({5'b11110, cp[20:18]}, 1'b0, 1'b0);
			b.item[1] = mk_res({2'b10, cp[17:12]}, 1'b0, 1'b0);
			b.item[2] = mk_res({2'b10, cp[11:6]}, 1'b0, 1'b0);
			b.item[3] = mk_res({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end
		return b;
	endfunction

endpackage

>>> design/x2u_if.sv
// ----------------------------------------------------------------------------
// x2u channel interfaces
// Valid/ready channels for entity characters in and utf-8 bytes out.
// ----------------------------------------------------------------------------
interface x2u_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       entity_start;

	modport source (output valid, char_in, entity_start, input ready);
	modport sink (input valid, char_in, entity_start, output ready);
endinterface

interface x2u_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;
	logic       is_error;

	modport source (output valid, out_byte, is_last, is_error, input ready);
	modport sink (input valid, out_byte, is_last, is_error, output ready);
endinterface

>>> design/x2u_decode.sv
// ----------------------------------------------------------------------------
// x2u_decode: per-character decode step
// Given the current decoder state and one character, computes the next state
// and the results (0 to 4 utf-8 bytes or one error) that the character causes.
// ----------------------------------------------------------------------------
module x2u_decode import x2u_pkg::*; (
	input  logic [7:0] char_in,
	input  logic       entity_start,
	input  dec_state_t cur,
	output dec_state_t nxt,
	output burst_t     burst
);

	logic              is_lower, is_upper, is_dig8, is_dig9, is_hexl, is_hexu;
	logic [HASH_W-1:0] hash_b;
	logic [LEN_W-1:0]  len_b;
	logic              hex_b;
	logic [ACC_W-1:0]  acc_b;
	logic              do_name, do_digit;
	logic              err, emit, hit;
	logic [ACC_W-1:0]  emit_cp, hit_cp;
	logic [5:0]        name_v;
	logic [3:0]        dig_v;
	logic [SUM_W-1:0]  acc_next;

	// character classes
	always_comb begin
		is_lower = (char_in >= CH_LO_A) && (char_in <= CH_LO_Z);
		is_upper = (char_in >= CH_UP_A) && (char_in <= CH_UP_Z);
		is_dig8  = (char_in >= CH_ZERO) && (char_in <= CH_EIGHT);
		is_dig9  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
		is_hexl  = (char_in >= CH_LO_A) && (char_in <= CH_LO_F);
		is_hexu  = (char_in >= CH_UP_A) && (char_in <= CH_UP_F);
	end

	// entity name lookup
	always_comb begin
		hit    = 1'b0;
		hit_cp = '0;
		for (int i = 0; i < N_ENT; i++) begin
			if (!hit && hash_b == ENT_HASH[i]) begin
				hit    = 1'b1;
				hit_cp = ENT_CP[i];
			end
		end
	end

	// hash value of a name character
	always_comb begin
		if (is_lower)
			name_v = 6'(char_in - CH_LO_A);
		else if (is_upper)
			name_v = 6'(char_in - CH_UP_A);
		else
			name_v = 6'(char_in - CH_ZERO) + NAME_DIGIT_BASE;
	end

	// digit value and accumulator step
	always_comb begin
		if (is_dig9)
			dig_v = 4'(char_in - CH_ZERO);
		else if (is_hexl)
			dig_v = 4'(char_in - CH_LO_A) + 4'd10;
		else
			dig_v = 4'(char_in - CH_UP_A) + 4'd10;
		if (hex_b)
			acc_next = {acc_b, 4'b0} + SUM_W'(dig_v);
		else
			acc_next = {acc_b, 3'b0} + {2'b0, acc_b, 1'b0} + SUM_W'(dig_v);
	end

	// state step
	always_comb begin
		nxt      = cur;
		hash_b   = cur.hash;
		len_b    = cur.len;
		hex_b    = cur.hex;
		acc_b    = cur.acc;
		do_name  = 1'b0;
		do_digit = 1'b0;
		err      = 1'b0;
		emit     = 1'b0;
		emit_cp  = '0;

		// entry: start of a new entity or continue in the current mode
		if (entity_start) begin
			nxt.hex = 1'b0;
			nxt.acc = '0;
			nxt.len = '0;
			hex_b   = 1'b0;
			acc_b   = '0;
			len_b   = '0;
			if (char_in == CH_HASH) begin
				nxt.hash = '0;
				nxt.mode = MODE_HASH;
			end else begin
				hash_b   = is_upper ? HASH_W'(1) : HASH_W'(2);
				nxt.hash = hash_b;
				nxt.mode = MODE_NAME;
				do_name  = 1'b1;
			end
		end else begin
			unique case (cur.mode)
				MODE_NAME: begin
					do_name = 1'b1;
				end
				MODE_HASH: begin
					nxt.mode = MODE_DIGITS;
					if (char_in == CH_X) begin
						nxt.hex = 1'b1;
					end else begin
						nxt.hex  = 1'b0;
						hex_b    = 1'b0;
						do_digit = 1'b1;
					end
				end
				MODE_DIGITS: begin
					do_digit = 1'b1;
				end
				default: begin
				end
			endcase
		end

		// name character
		if (do_name) begin
			if (char_in == CH_SEMI) begin
				if (len_b != '0 && hit) begin
					emit    = 1'b1;
					emit_cp = hit_cp;
				end else begin
					err = 1'b1;
				end
			end else if (is_lower || is_upper || is_dig8) begin
				if (len_b >= LEN_W'(MAX_NAME_CHARS)) begin
					err = 1'b1;
				end else begin
					nxt.len  = len_b + LEN_W'(1);
					nxt.hash = {hash_b[HASH_W-6:0], 5'b0} + HASH_W'(name_v);
				end
			end else begin
				err = 1'b1;
			end
		end

		// numeric reference character
		if (do_digit) begin
			if (char_in == CH_SEMI) begin
				if (len_b == '0) begin
					err = 1'b1;
				end else begin
					emit    = 1'b1;
					emit_cp = acc_b;
				end
			end else if (is_dig9 || (hex_b && (is_hexl || is_hexu))) begin
				if (acc_next > CP_LIMIT) begin
					err = 1'b1;
				end else begin
					nxt.acc = acc_next[ACC_W-1:0];
					nxt.len = LEN_W'(1);
				end
			end else begin
				err = 1'b1;
			end
		end

		// results
		burst = '0;
		if (err) begin
			nxt.mode      = MODE_IDLE;
			burst.count   = CNT_W'(1);
			burst.item[0] = mk_res(8'h00, 1'b1, 1'b1);
		end else if (emit) begin
			nxt.mode = MODE_IDLE;
			burst    = utf8_encode(emit_cp);
		end
	end

endmodule

>>> design/xml_entity_to_utf8.sv
// ----------------------------------------------------------------------------
// xml_entity_to_utf8: xml character entity decoder with utf-8 output
// Takes the characters after '&' one per transaction up to ';' and returns
// the decoded code point as 1 to 4 utf-8 bytes, or a single error byte.
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------
//  ent     | in  | char_in[7:0], entity_start       | valid/ready
//  utf8    | out | out_byte[7:0], is_last, is_error | valid/ready
//
// A character is registered on acceptance, decoded in the next cycle and its
// results loaded into a 4-entry burst register that drains one byte a cycle
// while utf8.ready is high. Characters that give no result pass at one per
// cycle; a character that gives bytes waits until the last byte of the
// previous burst is taken. Results pass the input stage and burst register.
// Reset (arst_n low) returns the decoder to idle and empties all stages.
// Output stalls hold the burst register and back up into the input stage.
// ----------------------------------------------------------------------------
module xml_entity_to_utf8 import x2u_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	x2u_in_if.sink     ent,
	x2u_out_if.source  utf8
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 start_s1;
	dec_state_t           state_q;
	dec_state_t           state_nxt;
	burst_t               burst;
	res_t [MAX_RES-1:0]   buf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pop, buf_free, adv_s1, load;

	// decode step
	x2u_decode u_decode (
		.char_in      (char_s1),
		.entity_start (start_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.burst        (burst)
	);

	// flow control
	assign pop      = (cnt_q != '0) && utf8.ready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && utf8.ready);
	assign adv_s1   = valid_s1 && ((burst.count == '0) || buf_free);
	assign load     = adv_s1 && (burst.count != '0);
	assign ent.ready = !valid_s1 || adv_s1;

	// output channel
	assign utf8.valid    = (cnt_q != '0);
	assign utf8.out_byte = buf_q[0].out_byte;
	assign utf8.is_last  = buf_q[0].is_last;
	assign utf8.is_error = buf_q[0].is_error;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
			state_q  <= '{mode: MODE_IDLE, hex: 1'b0, acc: '0, hash: '0, len: '0};
		end else begin
			if (ent.ready)
				valid_s1 <= ent.valid;
			if (adv_s1)
				state_q <= state_nxt;
			if (load)
				cnt_q <= burst.count;
			else if (pop)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (ent.ready && ent.valid) begin
			char_s1  <= ent.char_in;
			start_s1 <= ent.entity_start;
		end
	end

	// burst register: load a new burst or shift out one byte
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= burst.item;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				buf_q[i] <= buf_q[i+1];
		end
	end

endmodule
